>>> hdl/hrp_pkg.sv
package hrp_pkg;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_HT = 8'h09;

  // The three bytes before the final LF of a header end, oldest in the top byte.
  localparam logic [23:0] TAIL_CRLFCR = 24'h0D0A0D;

  localparam logic [10:0] HEADER_LIMIT_RESET = 11'd1024;
  localparam logic [3:0]  LEN_FIELD_CHARS = 4'd15;
  localparam int unsigned NUM_METHODS = 9;

  typedef enum logic [3:0] {
    M_GET     = 4'd0,
    M_HEAD    = 4'd1,
    M_POST    = 4'd2,
    M_PUT     = 4'd3,
    M_DELETE  = 4'd4,
    M_TRACE   = 4'd5,
    M_OPTIONS = 4'd6,
    M_CONNECT = 4'd7,
    M_PATCH   = 4'd8,
    M_NONE    = 4'd9
  } method_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_LARGE   = 3'd1,
    ST_BAD_METHOD  = 3'd2,
    ST_BAD_URL     = 3'd3,
    ST_POST_NO_LEN = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    logic       sor;
  } byte_word_t;

  typedef struct packed {
    status_e     status;
    method_e     method;
    logic [9:0]  url_offset;
    logic [9:0]  url_length;
    logic [10:0] header_length;
    logic [31:0] body_length;
    logic        length_present;
  } result_t;

  function automatic logic [2:0] method_len(input logic [3:0] k);
    logic [2:0] len;
    unique case (k)
      M_GET:     len = 3'd3;
      M_HEAD:    len = 3'd4;
      M_POST:    len = 3'd4;
      M_PUT:     len = 3'd3;
      M_DELETE:  len = 3'd6;
      M_TRACE:   len = 3'd5;
      M_OPTIONS: len = 3'd7;
      M_CONNECT: len = 3'd7;
      M_PATCH:   len = 3'd5;
      default:   len = 3'd0;
    endcase
    return len;
  endfunction

  // Character at position pos of a method name, first character at pos 0.
  function automatic logic [7:0] method_char(input logic [3:0] k, input logic [2:0] pos);
    logic [55:0] txt;
    logic [55:0] sh;
    unique case (k)
      M_GET:     txt = {"GET", 32'd0};
      M_HEAD:    txt = {"HEAD", 24'd0};
      M_POST:    txt = {"POST", 24'd0};
      M_PUT:     txt = {"PUT", 32'd0};
      M_DELETE:  txt = {"DELETE", 8'd0};
      M_TRACE:   txt = {"TRACE", 16'd0};
      M_OPTIONS: txt = "OPTIONS";
      M_CONNECT: txt = "CONNECT";
      M_PATCH:   txt = {"PATCH", 16'd0};
      default:   txt = '0;
    endcase
    sh = txt >> {3'd6 - pos, 3'b000};
    return sh[7:0];
  endfunction

  // Lower-case header name; position fifteen reads as zero.
  function automatic logic [7:0] name_char(input logic [3:0] pos);
    logic [127:0] txt;
    logic [127:0] sh;
    txt = {"content-length:", 8'd0};
    sh  = txt >> {4'd15 - pos, 3'b000};
    return sh[7:0];
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

>>> hdl/hrp_in_stage.sv
module hrp_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               start_of_request_i,
  output logic               word_valid_o,
  output hrp_pkg::byte_word_t word_o,
  input  logic               word_take_i
);
  import hrp_pkg::*;

  logic       valid_q, valid_d;
  byte_word_t word_q;

  // A held word may leave in the same cycle that the next one arrives.
  assign in_ready_o = !valid_q || word_take_i;

  always_comb begin
    valid_d = valid_q;
    if (word_take_i) valid_d = 1'b0;
    if (in_valid_i && in_ready_o) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q.data <= data_byte_i;
      word_q.sor  <= start_of_request_i;
    end
  end

  assign word_valid_o = valid_q;
  assign word_o       = word_q;

endmodule

>>> hdl/hrp_parser.sv
module hrp_parser #(
  parameter int unsigned MAX_HEADER_BYTES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [10:0]         cfg_wdata_i,
  input  hrp_pkg::byte_word_t word_i,
  input  logic                step_i,
  output logic                res_hit_o,
  output hrp_pkg::result_t    res_o
);
  import hrp_pkg::*;

  localparam int unsigned BW = $clog2(MAX_HEADER_BYTES + 1);
  localparam int unsigned CW = (BW > 11) ? BW : 11;

  typedef enum logic [1:0] {
    URL_BEFORE,
    URL_INSIDE,
    URL_DONE
  } url_phase_e;

  typedef enum logic [2:0] {
    LP_REQ_LINE,
    LP_NAME,
    LP_SPACE,
    LP_DIGITS,
    LP_SKIP
  } line_phase_e;

  logic [10:0]   limit_q;
  logic [BW-1:0] cnt_q, cnt_d;
  logic [23:0]   tail_q, tail_d;
  logic [8:0]    cand_q, cand_d;
  method_e       code_q, code_d;
  url_phase_e    uph_q, uph_d;
  logic [9:0]    ucnt_q, ucnt_d;
  line_phase_e   lph_q, lph_d;
  logic [3:0]    npos_q, npos_d;
  logic [31:0]   acc_q, acc_d;
  logic [31:0]   lval_q, lval_d;
  logic          lseen_q, lseen_d;
  logic          fin_q, fin_d;

  always_comb begin
    logic [7:0]    b;
    logic [BW-1:0] p;
    logic [CW-1:0] p_ext;
    logic [CW-1:0] cnt_ext;
    logic [CW-1:0] lim;
    logic [2:0]    p3;
    logic          picked;
    logic          hdr_end;
    logic [35:0]   acc10;

    b       = word_i.data;
    cnt_d   = cnt_q;
    tail_d  = tail_q;
    cand_d  = cand_q;
    code_d  = code_q;
    uph_d   = uph_q;
    ucnt_d  = ucnt_q;
    lph_d   = lph_q;
    npos_d  = npos_q;
    acc_d   = acc_q;
    lval_d  = lval_q;
    lseen_d = lseen_q;
    fin_d   = fin_q;

    res_hit_o            = 1'b0;
    res_o.status         = ST_OK;
    res_o.method         = M_NONE;
    res_o.url_offset     = '0;
    res_o.url_length     = '0;
    res_o.header_length  = '0;
    res_o.body_length    = '0;
    res_o.length_present = 1'b0;

    if (word_i.sor) begin
      cnt_d   = '0;
      tail_d  = '0;
      cand_d  = '1;
      code_d  = M_NONE;
      uph_d   = URL_BEFORE;
      ucnt_d  = '0;
      lph_d   = LP_REQ_LINE;
      npos_d  = '0;
      acc_d   = '0;
      lval_d  = '0;
      lseen_d = 1'b0;
      fin_d   = 1'b0;
    end

    p       = cnt_d;
    p_ext   = CW'(p);
    p3      = p[2:0];
    picked  = 1'b0;
    hdr_end = 1'b0;
    acc10   = '0;
    cnt_ext = '0;
    lim     = '0;

    if (!fin_d) begin
      cnt_d   = p + BW'(1);
      cnt_ext = CW'(cnt_d);

      // Method prefix match over the first seven bytes.
      if (p_ext < CW'(7)) begin
        for (int k = 0; k < NUM_METHODS; k++) begin
          if (p3 < method_len(4'(k)) && b != method_char(4'(k), p3)) cand_d[k] = 1'b0;
        end
        if (code_d == M_NONE) begin
          for (int k = 0; k < NUM_METHODS; k++) begin
            if (!picked && cand_d[k] && CW'(method_len(4'(k))) == p_ext + CW'(1)) begin
              code_d = method_e'(4'(k));
              picked = 1'b1;
            end
          end
        end
      end

      // URL tracking.
      if (code_d != M_NONE) begin
        if (uph_d == URL_BEFORE && p_ext == CW'(method_len(code_d)) + CW'(1)) begin
          uph_d = URL_INSIDE;
        end
        if (uph_d == URL_INSIDE) begin
          if (b == CH_CR || b == CH_LF || b == CH_SP || b == CH_HT) begin
            uph_d = URL_DONE;
          end else if (ucnt_d != 10'd1023) begin
            ucnt_d = ucnt_d + 10'd1;
          end
        end
      end

      // Header line tracking for the Content-Length field.
      acc10 = ({4'd0, acc_d} << 3) + ({4'd0, acc_d} << 1) + 36'(b - 8'h30);
      if (b == CH_LF && tail_d[7:0] == CH_CR && p_ext != '0) begin
        if (lph_d == LP_DIGITS) begin
          lval_d  = acc_d;
          lseen_d = 1'b1;
        end
        lph_d  = LP_NAME;
        npos_d = '0;
      end else begin
        case (lph_d)
          LP_NAME: begin
            if (to_lower(b) == name_char(npos_d)) begin
              npos_d = npos_d + 4'd1;
              if (npos_d >= LEN_FIELD_CHARS) lph_d = LP_SPACE;
            end else begin
              lph_d = LP_SKIP;
            end
          end
          LP_SPACE: begin
            if (is_digit(b)) begin
              acc_d = 32'(b - 8'h30);
              lph_d = LP_DIGITS;
            end else if (b != CH_SP && b != CH_HT) begin
              lph_d = LP_SKIP;
            end
          end
          LP_DIGITS: begin
            if (is_digit(b)) begin
              acc_d = (acc10[35:32] != '0) ? 32'hFFFF_FFFF : acc10[31:0];
            end else begin
              lval_d  = acc_d;
              lseen_d = 1'b1;
              lph_d   = LP_SKIP;
            end
          end
          default: ;
        endcase
      end

      hdr_end = (tail_d == TAIL_CRLFCR) && b == CH_LF;
      tail_d  = {tail_d[15:0], b};

      lim = (CW'(limit_q) < CW'(MAX_HEADER_BYTES)) ? CW'(limit_q) : CW'(MAX_HEADER_BYTES);

      if (hdr_end) begin
        fin_d     = 1'b1;
        res_hit_o = 1'b1;
        if (code_d == M_NONE) begin
          res_o.status = ST_BAD_METHOD;
        end else if (uph_d != URL_DONE) begin
          res_o.status = ST_BAD_URL;
          res_o.method = code_d;
        end else begin
          res_o.method        = code_d;
          res_o.url_offset    = 10'(method_len(code_d)) + 10'd1;
          res_o.url_length    = ucnt_d;
          res_o.header_length = cnt_ext[10:0];
          if (code_d == M_POST && !lseen_d) begin
            res_o.status = ST_POST_NO_LEN;
          end else begin
            res_o.body_length    = lseen_d ? lval_d : '0;
            res_o.length_present = lseen_d;
          end
        end
      end else if (cnt_ext >= lim) begin
        fin_d        = 1'b1;
        res_hit_o    = 1'b1;
        res_o.status = ST_TOO_LARGE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= HEADER_LIMIT_RESET;
      cnt_q   <= '0;
      tail_q  <= '0;
      cand_q  <= '1;
      code_q  <= M_NONE;
      uph_q   <= URL_BEFORE;
      ucnt_q  <= '0;
      lph_q   <= LP_REQ_LINE;
      npos_q  <= '0;
      acc_q   <= '0;
      lval_q  <= '0;
      lseen_q <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (step_i) begin
        cnt_q   <= cnt_d;
        tail_q  <= tail_d;
        cand_q  <= cand_d;
        code_q  <= code_d;
        uph_q   <= uph_d;
        ucnt_q  <= ucnt_d;
        lph_q   <= lph_d;
        npos_q  <= npos_d;
        acc_q   <= acc_d;
        lval_q  <= lval_d;
        lseen_q <= lseen_d;
        fin_q   <= fin_d;
      end
    end
  end

endmodule

>>> hdl/hrp_out_stage.sv
module hrp_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  hrp_pkg::result_t res_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hrp_pkg::result_t res_o
);
  import hrp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && out_ready_i) valid_d = 1'b0;
    if (load_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> hdl/http_request_header_parser_core.sv
// An accepted word waits in the input register; any result it yields is registered in the result register.
// Throughput: one word per cycle. While a result waits to be collected, one more word is
// taken and held, and the input then stalls until the result leaves.
// The per-word state update is a single short pass between the input and result registers.
// Reset (rst_ni low, asynchronous) empties both registers, clears the per-request state
// and sets header_limit to 1024.
module http_request_header_parser_core #(
  parameter int unsigned MAX_HEADER_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_request_i,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [3:0]  method_o,
  output logic [9:0]  url_offset_o,
  output logic [9:0]  url_length_o,
  output logic [10:0] header_length_o,
  output logic [31:0] body_length_o,
  output logic        length_present_o
);
  import hrp_pkg::*;

  byte_word_t word;
  logic       word_valid;
  logic       out_free;
  logic       step;
  logic       res_hit;
  result_t    res_next;
  result_t    res_out;

  // The held word moves through the parser whenever the result register can take
  // what it might produce. Words that produce no result still wait for that slot,
  // so a stalled result holds up the input as well.
  assign step = word_valid && out_free;

  hrp_in_stage u_in (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .start_of_request_i(start_of_request_i),
    .word_valid_o      (word_valid),
    .word_o            (word),
    .word_take_i       (step)
  );

  // The parser holds all per-request state and the header_limit register. It works out
  // the next state and any result from the held word in one pass; the state is only
  // committed when the word steps.
  hrp_parser #(
    .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .word_i     (word),
    .step_i     (step),
    .res_hit_o  (res_hit),
    .res_o      (res_next)
  );

  hrp_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step && res_hit),
    .res_i      (res_next),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res_out)
  );

  assign status_o         = res_out.status;
  assign method_o         = res_out.method;
  assign url_offset_o     = res_out.url_offset;
  assign url_length_o     = res_out.url_length;
  assign header_length_o  = res_out.header_length;
  assign body_length_o    = res_out.body_length;
  assign length_present_o = res_out.length_present;

endmodule

>>> hdl/hrp_checker.sv
module hrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [3:0]  method_o,
  input logic [9:0]  url_offset_o,
  input logic [9:0]  url_length_o,
  input logic [10:0] header_length_o,
  input logic [31:0] body_length_o,
  input logic        length_present_o
);
  import hrp_pkg::*;

  // A stalled result word keeps its status, method, header length and body length.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(method_o)
      && $stable(header_length_o) && $stable(body_length_o))
    else $error("result word changed while stalled");

  // Size and method errors carry no other information.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_TOO_LARGE || status_o == ST_BAD_METHOD)
      |-> method_o == M_NONE && url_offset_o == '0 && url_length_o == '0
          && header_length_o == '0 && body_length_o == '0 && !length_present_o)
    else $error("error result with non-zero fields");

  // A good result names a method and a header that holds at least the blank line.
  a_ok_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |-> method_o != M_NONE && url_offset_o >= 10'd4
      && url_offset_o <= 10'd8 && header_length_o >= 11'd4)
    else $error("malformed good result");

  a_len_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !length_present_o |-> body_length_o == '0)
    else $error("body length without Content-Length");

  a_post_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_POST_NO_LEN |-> method_o == M_POST && !length_present_o)
    else $error("missing-length status on a request that is not a POST");

endmodule

bind http_request_header_parser_core hrp_checker u_hrp_checker (.*);

>>> tb/http_request_header_parser_core_tb.sv
module http_request_header_parser_core_tb;

  import hrp_pkg::*;

  // Default MAX_HEADER_BYTES of the block; the register value is clipped to this.
  localparam int unsigned MAX_HDR      = 1024;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE       = 6;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned MAX_SHOWN    = 10;

  // Header limits of the random phases and the least number of words sent in each.
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned PHASE_LIM    [NUM_PHASES] = '{1024, 64, 4, 2047, 0, 1, 30, 1024};
  localparam int unsigned PHASE_BUDGET [NUM_PHASES] = '{200, 90, 40, 140, 30, 30, 60, 110};

  typedef enum logic [1:0] {URL_BEFORE, URL_IN, URL_DONE} url_phase_e;
  typedef enum logic [2:0] {LN_REQ, LN_NAME, LN_SPACE, LN_DIGITS, LN_SKIP} line_phase_e;

  // One row of the directed table: the header limit to use, whether the text carries on
  // the request already open, the bytes themselves and, where it is obvious, the summary.
  typedef struct {
    int unsigned lim;
    bit          cont;
    string       txt;
    bit          fixed;
    result_t     want;
  } row_t;

  // Clock, reset and the block's inputs, all known from time zero.
  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        in_valid_i         = 1'b0;
  logic [7:0]  data_byte_i        = 8'h00;
  logic        start_of_request_i = 1'b0;
  logic        cfg_we_i           = 1'b0;
  logic [10:0] cfg_wdata_i        = 11'd0;
  logic        out_ready_i        = 1'b0;

  logic        in_ready_o;
  logic        out_valid_o;
  logic [2:0]  status_o;
  logic [3:0]  method_o;
  logic [9:0]  url_offset_o;
  logic [9:0]  url_length_o;
  logic [10:0] header_length_o;
  logic [31:0] body_length_o;
  logic        length_present_o;

  always #6 clk_i = ~clk_i;

  http_request_header_parser_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .start_of_request_i (start_of_request_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .method_o           (method_o),
    .url_offset_o       (url_offset_o),
    .url_length_o       (url_length_o),
    .header_length_o    (header_length_o),
    .body_length_o      (body_length_o),
    .length_present_o   (length_present_o)
  );

  // Method names in the order in which a prefix match prefers them.
  string method_txt [NUM_METHODS] = '{"GET", "HEAD", "POST", "PUT", "DELETE", "TRACE",
                                      "OPTIONS", "CONNECT", "PATCH"};
  string len_name = "content-length:";

  // Shadow of the parser: its own copy of the per-request state and of the register.
  logic [10:0]  hp_limit = HEADER_LIMIT_RESET;
  int unsigned  hp_count;
  logic [23:0]  hp_tail;
  logic [8:0]   hp_cand;
  method_e      hp_method;
  url_phase_e   hp_url;
  int unsigned  hp_url_len;
  line_phase_e  hp_line;
  int unsigned  hp_name_pos;
  logic [31:0]  hp_acc;
  logic [31:0]  hp_len;
  bit           hp_len_seen;
  bit           hp_done;

  // Summaries the block still owes, oldest first.
  result_t pending_results [$];

  // Directed rows may replace the computed summary with one typed into the table.
  bit      use_fixed = 1'b0;
  result_t fixed_want;

  // Shared between the sending and receiving processes.
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;

  int unsigned errors      = 0;
  int unsigned checked     = 0;
  int unsigned live_bytes  = 0;
  int unsigned sent_words  = 0;
  int unsigned requests    = 0;
  int unsigned limit_wrs   = 0;

  row_t       dir_rows  [$];
  logic [7:0] req_bytes [$];

  function automatic void hdr_restart();
    hp_count    = 0;
    hp_tail     = '0;
    hp_cand     = '1;
    hp_method   = M_NONE;
    hp_url      = URL_BEFORE;
    hp_url_len  = 0;
    hp_line     = LN_REQ;
    hp_name_pos = 0;
    hp_acc      = '0;
    hp_len      = '0;
    hp_len_seen = 1'b0;
    hp_done     = 1'b0;
  endfunction

  // Advances the shadow parser by one word and returns 1 when that word yields a summary.
  function automatic bit parse_byte(input logic [7:0] b, input logic sor, output result_t res);
    int unsigned p;
    int unsigned k;
    int unsigned lim;
    logic [7:0]  lc;
    logic [7:0]  prev;
    logic [63:0] grown;
    bit          hdr_end;
    bit          found;
    res = '0;
    if (sor) hdr_restart();
    if (hp_done) return 1'b0;
    p = hp_count;
    hp_count = p + 1;

    // The method is settled by the first candidate whose full name has just matched.
    if (p < 7) begin
      for (k = 0; k < NUM_METHODS; k++)
        if (p < method_txt[k].len() && b != method_txt[k][p]) hp_cand[k] = 1'b0;
      if (hp_method == M_NONE) begin
        found = 1'b0;
        for (k = 0; k < NUM_METHODS; k++) begin
          if (!found && hp_cand[k] && method_txt[k].len() == p + 1) begin
            hp_method = method_e'(k);
            found = 1'b1;
          end
        end
      end
    end

    // The URL opens one byte after the method, whatever that byte is.
    if (hp_method != M_NONE) begin
      if (hp_url == URL_BEFORE && p == method_txt[int'(hp_method)].len() + 1) hp_url = URL_IN;
      if (hp_url == URL_IN) begin
        if (b == CH_CR || b == CH_LF || b == CH_SP || b == CH_HT) hp_url = URL_DONE;
        else if (hp_url_len < 1023) hp_url_len++;
      end
    end

    prev = hp_tail[7:0];
    lc   = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    if (b == CH_LF && prev == CH_CR && p > 0) begin
      if (hp_line == LN_DIGITS) begin
        hp_len      = hp_acc;
        hp_len_seen = 1'b1;
      end
      hp_line     = LN_NAME;
      hp_name_pos = 0;
    end else if (hp_line == LN_NAME) begin
      if (lc == len_name[hp_name_pos]) begin
        hp_name_pos++;
        if (hp_name_pos >= len_name.len()) hp_line = LN_SPACE;
      end else begin
        hp_line = LN_SKIP;
      end
    end else if (hp_line == LN_SPACE) begin
      if (b >= 8'h30 && b <= 8'h39) begin
        hp_acc  = b - 8'h30;
        hp_line = LN_DIGITS;
      end else if (b != CH_SP && b != CH_HT) begin
        hp_line = LN_SKIP;
      end
    end else if (hp_line == LN_DIGITS) begin
      if (b >= 8'h30 && b <= 8'h39) begin
        grown  = hp_acc * 64'd10 + (b - 8'h30);
        hp_acc = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
      end else begin
        hp_len      = hp_acc;
        hp_len_seen = 1'b1;
        hp_line     = LN_SKIP;
      end
    end

    hdr_end = (hp_tail == TAIL_CRLFCR) && b == CH_LF;
    hp_tail = {hp_tail[15:0], b};

    if (hdr_end) begin
      hp_done = 1'b1;
      if (hp_method == M_NONE) begin
        res.status = ST_BAD_METHOD;
        res.method = M_NONE;
      end else if (hp_url != URL_DONE) begin
        res.status = ST_BAD_URL;
        res.method = hp_method;
      end else begin
        res.method        = hp_method;
        res.url_offset    = 10'(method_txt[int'(hp_method)].len() + 1);
        res.url_length    = 10'(hp_url_len);
        res.header_length = 11'(hp_count);
        if (hp_method == M_POST && !hp_len_seen) begin
          res.status = ST_POST_NO_LEN;
        end else begin
          res.status         = ST_OK;
          res.body_length    = hp_len_seen ? hp_len : 32'd0;
          res.length_present = hp_len_seen;
        end
      end
      return 1'b1;
    end

    lim = (hp_limit < MAX_HDR) ? hp_limit : MAX_HDR;
    if (hp_count >= lim) begin
      hp_done    = 1'b1;
      res.status = ST_TOO_LARGE;
      res.method = M_NONE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t make_result(status_e st, method_e m, int unsigned uo,
                                          int unsigned ul, int unsigned hl,
                                          logic [31:0] bl, bit lp);
    result_t r;
    r.status         = st;
    r.method         = m;
    r.url_offset     = 10'(uo);
    r.url_length     = 10'(ul);
    r.header_length  = 11'(hl);
    r.body_length    = bl;
    r.length_present = lp;
    return r;
  endfunction

  function automatic string describe(result_t r);
    return $sformatf("status=%0d method=%0d url_off=%0d url_len=%0d hdr_len=%0d body=%0d len=%0b",
                     r.status, r.method, r.url_offset, r.url_length, r.header_length,
                     r.body_length, r.length_present);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  task automatic add_row(int unsigned lim, bit cont, string txt, bit fixed, result_t want);
    row_t r;
    r.lim   = lim;
    r.cont  = cont;
    r.txt   = txt;
    r.fixed = fixed;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  task automatic add_text(string s);
    int unsigned i;
    for (i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endtask

  // Offers one word and returns at the rising edge at which it is taken. Valid is only
  // lowered when a gap is wanted, so back-to-back words keep it high throughout.
  task automatic push_byte(input logic [7:0] b, input logic sor);
    int unsigned gap;
    gap = quiet ? 0 : (($urandom_range(0, 99) < 65) ? 0 : pick_gap());
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    data_byte_i        <= b;
    start_of_request_i <= sor;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // The register is only written once the block has gone quiet: nothing owed, and a few
  // cycles more for a word still in flight that yields no summary.
  task automatic set_limit(input logic [10:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hp_limit = v;
    limit_wrs++;
  endtask

  // Builds one random request into req_bytes. Most are well formed with random content;
  // the rest are noise, made-up methods, cut-off requests and junk after the end.
  task automatic build_request(output bit noisy);
    int unsigned kind;
    int unsigned n;
    int unsigned m;
    int unsigned i;
    int unsigned j;
    int unsigned nd;
    logic [7:0]  c;
    string       cl;
    cl = "Content-Length:";
    req_bytes.delete();
    kind  = $urandom_range(0, 99);
    noisy = (kind < 8);
    if (noisy) begin
      n = $urandom_range(1, 40);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          req_bytes.push_back(CH_CR);
          req_bytes.push_back(CH_LF);
        end else begin
          req_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
      return;
    end

    m = $urandom_range(0, NUM_METHODS);
    if (m == NUM_METHODS) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) req_bytes.push_back(8'($urandom_range(8'h41, 8'h5A)));
    end else begin
      add_text(method_txt[m]);
    end
    if ($urandom_range(0, 9) != 0) req_bytes.push_back(($urandom_range(0, 7) == 0) ? CH_HT : CH_SP);

    // Now and then a long URL; a stray tab cuts it short.
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 250) : $urandom_range(0, 16);
    for (i = 0; i < n; i++)
      req_bytes.push_back(($urandom_range(0, 49) == 0) ? CH_HT : 8'($urandom_range(8'h21, 8'hFF)));
    if ($urandom_range(0, 1) == 1) add_text(" HTTP/1.1");
    req_bytes.push_back(CH_CR);
    req_bytes.push_back(CH_LF);

    n = $urandom_range(0, 4);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          for (j = 0; j < cl.len(); j++) begin
            c = cl[j];
            if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
                $urandom_range(0, 1) == 1)
              c = c ^ 8'h20;
            req_bytes.push_back(c);
          end
          nd = $urandom_range(0, 3);
          for (j = 0; j < nd; j++) req_bytes.push_back(($urandom_range(0, 1) == 1) ? CH_HT : CH_SP);
          case ($urandom_range(0, 7))
            0:       nd = 0;
            1:       nd = $urandom_range(10, 14);
            default: nd = $urandom_range(1, 6);
          endcase
          if (nd == 10 && $urandom_range(0, 1) == 1) begin
            add_text("4294967295");
          end else begin
            for (j = 0; j < nd; j++) req_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
          end
          if ($urandom_range(0, 5) == 0) add_text(";x");
        end
        2: begin
          add_text(cl.substr(0, $urandom_range(0, 13)));
          add_text("X: 1");
        end
        default: begin
          add_text("Host: ");
          nd = $urandom_range(1, 8);
          for (j = 0; j < nd; j++) req_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end
      endcase
      req_bytes.push_back(CH_CR);
      req_bytes.push_back(CH_LF);
    end
    req_bytes.push_back(CH_CR);
    req_bytes.push_back(CH_LF);

    if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, req_bytes.size() - 1);
      repeat (n) void'(req_bytes.pop_back());
    end
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) req_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Every word taken is fed to the shadow parser, and every summary handed over is checked
  // against the oldest one still owed. All values are sampled as they stood before the edge.
  always @(posedge clk_i) begin : scoreboard
    result_t pred;
    result_t got;
    result_t want;
    if (in_valid_i && in_ready_o) begin
      sent_words++;
      if (start_of_request_i || !hp_done) live_bytes++;
      if (parse_byte(data_byte_i, start_of_request_i, pred))
        pending_results.push_back(use_fixed ? fixed_want : pred);
    end
    if (out_valid_o && out_ready_i) begin
      got.status         = status_e'(status_o);
      got.method         = method_e'(method_o);
      got.url_offset     = url_offset_o;
      got.url_length     = url_length_o;
      got.header_length  = header_length_o;
      got.body_length    = body_length_o;
      got.length_present = length_present_o;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: summary with none owed: %s", $realtime, describe(got));
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (got.status !== want.status || got.method !== want.method ||
            got.url_offset !== want.url_offset || got.url_length !== want.url_length ||
            got.header_length !== want.header_length ||
            got.body_length !== want.body_length ||
            got.length_present !== want.length_present) begin
          errors++;
          if (errors <= MAX_SHOWN) begin
            $display("%0t: summary mismatch", $realtime);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
          end
        end
      end
    end
  end

  // Output side: random stalls, none while the stimulus asks for a quiet stretch, and one
  // long hold-off on request so that the block fills up and stops taking words.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (quiet || stall_left == 0) begin
        out_ready_i <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end else begin
        out_ready_i <= 1'b0;
        stall_left--;
      end
    end
  end

  // Kill switch, well beyond the slowest correct run.
  initial begin : watchdog
    #(12 * 800000);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned i;
    int unsigned ph;
    int unsigned target;
    logic [7:0]  b;
    bit          noisy;

    hdr_restart();

    // Directed table. A byte 0x01 in the text stands for a zero byte, which a string
    // literal cannot carry. Summaries are typed in only where they are plain to see.
    add_row(1024, 0, "GET / HTTP/1.1\r\n\r\n", 1,
            make_result(ST_OK, M_GET, 4, 1, 18, 0, 0));
    add_row(1024, 0, "HEAD /a\r\n\r\n", 1, make_result(ST_OK, M_HEAD, 5, 2, 11, 0, 0));
    add_row(1024, 0, "POST /p HTTP/1.1\r\nContent-Length: 12\r\n\r\n", 0, '0);
    add_row(1024, 0, "POST /p\r\n\r\n", 1, make_result(ST_POST_NO_LEN, M_POST, 5, 2, 11, 0, 0));
    add_row(1024, 0, "PUT /x\r\ncontent-LENGTH:\t4294967295\r\n\r\n", 0, '0);
    add_row(1024, 0, "DELETE /d\r\nContent-Length: 99999999999\r\n\r\n", 0, '0);
    add_row(1024, 0, "TRACE * HTTP/1.1\r\nContent-Length: 5\r\nCONTENT-length:7\r\n\r\n", 0, '0);
    add_row(1024, 0, "OPTIONS *\r\nX-Content-Length: 3\r\nContent-Length:\r\n\r\n", 0, '0);
    add_row(1024, 0, "CONNECT h:1\r\nContent-Length: 4294967296\r\n\r\n", 0, '0);
    add_row(1024, 0, "PATCH /q\tx\r\n\r\n", 0, '0);
    add_row(1024, 0, "GETX\r\n\r\n", 0, '0);
    add_row(1024, 0, "GET /\001\377\r\n\r\nXYZ", 0, '0);
    add_row(1024, 0, "BREW /\r\n\r\n", 1, make_result(ST_BAD_METHOD, M_NONE, 0, 0, 0, 0, 0));
    add_row(1024, 0, "\r\n\r\n", 1, make_result(ST_BAD_METHOD, M_NONE, 0, 0, 0, 0, 0));
    add_row(4, 0, "GET /", 1, make_result(ST_TOO_LARGE, M_NONE, 0, 0, 0, 0, 0));
    add_row(4, 0, "\r\n\r\n", 1, make_result(ST_BAD_METHOD, M_NONE, 0, 0, 0, 0, 0));
    add_row(0, 0, "G", 1, make_result(ST_TOO_LARGE, M_NONE, 0, 0, 0, 0, 0));
    add_row(2047, 0, "PUT /big HTTP/1.1\r\nContent-Length: 0\r\n\r\n", 0, '0);
    // A limit lowered under the count of an open request stops it at the next word.
    add_row(1024, 0, "GET /abcdef", 0, '0);
    add_row(8, 1, "g", 1, make_result(ST_TOO_LARGE, M_NONE, 0, 0, 0, 0, 0));
    add_row(1024, 0, "POST /u\r\nContent-Length: 1\r\n\r\n", 0, '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < dir_rows.size(); r++) begin
      if (dir_rows[r].lim != hp_limit) set_limit(11'(dir_rows[r].lim));
      use_fixed  = dir_rows[r].fixed;
      fixed_want = dir_rows[r].want;
      for (i = 0; i < dir_rows[r].txt.len(); i++) begin
        b = dir_rows[r].txt[i];
        if (b == 8'h01) b = 8'h00;
        push_byte(b, i == 0 && !dir_rows[r].cont);
      end
      // An idle edge between rows so that the next row's choice of summary cannot race this row's last word.
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      requests++;
    end
    use_fixed = 1'b0;

    // Back-pressure: the output side holds off while short requests keep coming, so the
    // block must fill up and stall its input.
    quiet    = 1'b1;
    hold_req = 1'b1;
    for (r = 0; r < 30; r++) begin
      req_bytes.delete();
      add_text("GET /x\r\n\r\n");
      foreach (req_bytes[k]) push_byte(req_bytes[k], k == 0);
      requests++;
    end
    quiet = 1'b0;

    // Random phases, each under its own header limit.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      set_limit(11'(PHASE_LIM[ph]));
      target = sent_words + PHASE_BUDGET[ph];
      while (sent_words < target) begin
        quiet = ($urandom_range(0, 7) == 0);
        build_request(noisy);
        foreach (req_bytes[k])
          push_byte(req_bytes[k], k == 0 || (noisy && $urandom_range(0, 19) == 0));
        requests++;
      end
    end
    quiet = 1'b0;

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests in %0d words, %0d of them parsed; %0d summaries checked.",
             requests, sent_words, live_bytes, checked);
    $display("%0d limit writes from 0 to 2047, with one %0d-cycle hold-off on the output side.",
             limit_wrs, HOLD_CYCLES);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
